@@ hdl/length_prefixed_block_ring_macros.svh @@
// Assertion helpers for the checker file.
`ifndef LENGTH_PREFIXED_BLOCK_RING_MACROS_SVH
`define LENGTH_PREFIXED_BLOCK_RING_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lpbr_pkg.sv @@
`default_nettype none
package lpbr_pkg;

  localparam int unsigned LEN_W            = 12;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned CMD_W            = 3;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned EVICT_W          = 10;
  localparam int unsigned STORED_W         = 13;
  localparam int unsigned DEF_BUFFER_BYTES = 4096;
  localparam int unsigned DEF_HEADER_BYTES = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BEGIN = 3'd0,
    CMD_PUSH_DATA  = 3'd1,
    CMD_POP_BEGIN  = 3'd2,
    CMD_POP_DATA   = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_EXCEEDS    = 3'd3,
    ST_SEQUENCE   = 3'd4
  } status_e;

  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [EVICT_W-1:0]  evict_t;
  typedef logic [STORED_W-1:0] stored_t;

endpackage
`default_nettype wire

@@ hdl/lpbr_if.sv @@
`default_nettype none
interface lpbr_in_if;
  import lpbr_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  len_t  length;
  byte_t data_byte;

  modport source (output valid, cmd, length, data_byte, input ready);
  modport sink (input valid, cmd, length, data_byte, output ready);
  modport monitor (input valid, cmd, length, data_byte, ready);
endinterface

interface lpbr_out_if;
  import lpbr_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  byte_t   read_byte;
  len_t    block_length;
  logic    last_byte;
  evict_t  evicted_blocks;
  stored_t stored_bytes;
  len_t    front_block_size;

  modport source (output valid, status, read_byte, block_length, last_byte,
                  evicted_blocks, stored_bytes, front_block_size, input ready);
  modport sink (input valid, status, read_byte, block_length, last_byte,
                evicted_blocks, stored_bytes, front_block_size, output ready);
  modport monitor (input valid, ready, status, read_byte, block_length, last_byte,
                   evicted_blocks, stored_bytes, front_block_size);
endinterface
`default_nettype wire

@@ hdl/length_prefixed_block_ring.sv @@
// Byte ring holding variable-length blocks, each stored behind a little-endian
// length header. Commands arrive on in_i (push_begin, push_data, pop_begin,
// pop_data, clear) and every command beat yields exactly one result beat on
// out_o, in order.
// One command is in flight at a time: in_i.ready is high only when the
// sequencer is idle and the result register is empty. Push_data, pop_begin,
// clear and rejected commands present their result the cycle after the beat
// is taken. Pop_data passes through a wait state for the registered memory
// read; the pop that ends a block also rereads the next header unless the ring
// is then empty. Push_begin first drops oldest blocks until the new block fits,
// each drop walking the next header through the single read port of the store
// unless it empties the ring, and then writes the header byte by byte.
// Reset empties the ring and returns to idle at once; the store itself is
// not cleared. When the receiver stalls, the result stays on out_o and no
// new command is taken until it is accepted.
`default_nettype none
module length_prefixed_block_ring #(
  parameter int unsigned BUFFER_BYTES = lpbr_pkg::DEF_BUFFER_BYTES,
  parameter int unsigned HEADER_BYTES = lpbr_pkg::DEF_HEADER_BYTES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpbr_in_if.sink    in_i,
  lpbr_out_if.source out_o
);
  import lpbr_pkg::*;

  localparam int unsigned AW  = $clog2(BUFFER_BYTES);
  localparam int unsigned UW  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned WW  = ((UW > LEN_W) ? UW : LEN_W) + 2;
  localparam int unsigned HCW = $clog2(HEADER_BYTES + 1);
  localparam bit          HDR_LIMITS = (8 * HEADER_BYTES < LEN_W);
  localparam int unsigned LIM_SH     = HDR_LIMITS ? 8 * HEADER_BYTES : 0;

  typedef enum logic [2:0] {
    S_IDLE, S_EVICT, S_HDR_WR, S_HDR_RD, S_POP_WAIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_PUSH, MODE_POP
  } mode_e;

  function automatic logic [AW-1:0] wrap(input logic [WW-1:0] p);
    logic [WW-1:0] r;
    r = (p >= WW'(BUFFER_BYTES)) ? p - WW'(BUFFER_BYTES) : p;
    return r[AW-1:0];
  endfunction

  state_e         state_q;
  mode_e          mode_q;
  logic [AW-1:0]  start_q, cur_q;
  logic [UW-1:0]  used_q;
  len_t           rem_q, front_q, len_q, acc_q;
  evict_t         evict_q;
  logic [HCW-1:0] hk_q;
  logic           ret_evict_q;

  logic    out_valid_q;
  status_t out_st_q;
  byte_t   out_rb_q;
  len_t    out_bl_q, out_fb_q;
  logic    out_lb_q;
  evict_t  out_ev_q;
  stored_t out_sb_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  byte_t         ram_wdata, ram_rdata;

  logic          accept;
  logic [WW-1:0] need, drop_total;
  logic          drop_empty, bad_len, must_evict;
  logic [UW-1:0] drop_used;
  logic [AW-1:0] drop_start;
  logic [5:0]    rd_sh;
  logic [31:0]   rd_wide;
  len_t          hdr_val;
  byte_t         hdr_byte;

  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    need       = WW'(len_q) + WW'(HEADER_BYTES);
    must_evict = (WW'(used_q) + need) > WW'(BUFFER_BYTES);
    bad_len    = (in_i.length == '0)
              || ((WW'(in_i.length) + WW'(HEADER_BYTES)) > WW'(BUFFER_BYTES))
              || (HDR_LIMITS && ((32'(in_i.length) >> LIM_SH) != 32'd0));
    drop_total = WW'(HEADER_BYTES) + WW'(front_q);
    drop_empty = (WW'(front_q) >= WW'(BUFFER_BYTES)) || (drop_total >= WW'(used_q));
    drop_used  = UW'(WW'(used_q) - drop_total);
    drop_start = wrap(WW'(start_q) + drop_total);
    rd_sh      = (hk_q == '0) ? 6'd0 : 6'(8 * (32'(hk_q) - 32'd1));
    rd_wide    = 32'(ram_rdata) << rd_sh;
    hdr_val    = acc_q | rd_wide[LEN_W-1:0];
    hdr_byte   = 8'(32'(len_q) >> (8 * 32'(hk_q)));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = in_i.data_byte;
    ram_raddr = cur_q;
    case (state_q)
      S_IDLE: begin
        if (accept && in_i.cmd == CMD_PUSH_DATA && mode_q == MODE_PUSH && rem_q != '0) begin
          ram_we = 1'b1;
        end
      end
      S_HDR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = hdr_byte;
      end
      S_HDR_RD: begin
        ram_raddr = wrap(WW'(start_q) + WW'(hk_q));
      end
      default: begin
      end
    endcase
  end

  lpbr_ram #(
    .Width(BYTE_W),
    .Depth(BUFFER_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_IDLE;
      start_q     <= '0;
      cur_q       <= '0;
      used_q      <= '0;
      rem_q       <= '0;
      front_q     <= '0;
      len_q       <= '0;
      acc_q       <= '0;
      evict_q     <= '0;
      hk_q        <= '0;
      ret_evict_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_rb_q    <= '0;
      out_bl_q    <= '0;
      out_fb_q    <= '0;
      out_lb_q    <= 1'b0;
      out_ev_q    <= '0;
      out_sb_q    <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_valid_q <= 1'b1;
            out_st_q    <= ST_OK;
            out_rb_q    <= '0;
            out_bl_q    <= '0;
            out_lb_q    <= 1'b0;
            out_ev_q    <= '0;
            out_sb_q    <= STORED_W'(used_q);
            out_fb_q    <= front_q;
            case (in_i.cmd)
              CMD_PUSH_BEGIN: begin
                if (mode_q != MODE_IDLE) begin
                  out_st_q <= ST_SEQUENCE;
                end else if (bad_len) begin
                  out_st_q <= ST_BAD_LENGTH;
                end else begin
                  out_valid_q <= 1'b0;
                  len_q       <= in_i.length;
                  evict_q     <= '0;
                  state_q     <= S_EVICT;
                end
              end
              CMD_PUSH_DATA: begin
                if (mode_q != MODE_PUSH || rem_q == '0) begin
                  out_st_q <= ST_SEQUENCE;
                end else begin
                  rem_q <= rem_q - 1'b1;
                  cur_q <= wrap(WW'(cur_q) + WW'(1));
                  if (rem_q == LEN_W'(1)) begin
                    out_lb_q <= 1'b1;
                    mode_q   <= MODE_IDLE;
                    cur_q    <= '0;
                  end
                end
              end
              CMD_POP_BEGIN: begin
                if (mode_q != MODE_IDLE) begin
                  out_st_q <= ST_SEQUENCE;
                end else if (used_q == '0) begin
                  out_st_q <= ST_EMPTY;
                end else if (front_q == '0 || front_q > in_i.length) begin
                  out_st_q <= ST_EXCEEDS;
                  out_bl_q <= front_q;
                end else begin
                  out_bl_q <= front_q;
                  cur_q    <= wrap(WW'(start_q) + WW'(HEADER_BYTES));
                  rem_q    <= front_q;
                  mode_q   <= MODE_POP;
                end
              end
              CMD_POP_DATA: begin
                if (mode_q != MODE_POP || rem_q == '0) begin
                  out_st_q <= ST_SEQUENCE;
                end else begin
                  out_valid_q <= 1'b0;
                  state_q     <= S_POP_WAIT;
                end
              end
              CMD_CLEAR: begin
                used_q   <= '0;
                start_q  <= '0;
                rem_q    <= '0;
                cur_q    <= '0;
                mode_q   <= MODE_IDLE;
                front_q  <= '0;
                out_sb_q <= '0;
                out_fb_q <= '0;
              end
              default: begin
                out_st_q <= ST_SEQUENCE;
              end
            endcase
          end
        end
        S_EVICT: begin
          if (must_evict) begin
            if (evict_q != '1) begin
              evict_q <= evict_q + 1'b1;
            end
            if (drop_empty) begin
              used_q  <= '0;
              start_q <= '0;
              front_q <= '0;
            end else begin
              used_q      <= drop_used;
              start_q     <= drop_start;
              hk_q        <= '0;
              acc_q       <= '0;
              ret_evict_q <= 1'b1;
              state_q     <= S_HDR_RD;
            end
          end else begin
            cur_q   <= wrap(WW'(start_q) + WW'(used_q));
            hk_q    <= '0;
            state_q <= S_HDR_WR;
          end
        end
        S_HDR_WR: begin
          cur_q <= wrap(WW'(cur_q) + WW'(1));
          hk_q  <= hk_q + 1'b1;
          if (hk_q == HCW'(HEADER_BYTES - 1)) begin
            used_q      <= UW'(WW'(used_q) + need);
            rem_q       <= len_q;
            mode_q      <= MODE_PUSH;
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            out_st_q    <= ST_OK;
            out_rb_q    <= '0;
            out_bl_q    <= len_q;
            out_lb_q    <= 1'b0;
            out_ev_q    <= evict_q;
            out_sb_q    <= STORED_W'(WW'(used_q) + need);
            // A block pushed into an empty ring becomes the front block.
            if (used_q == '0) begin
              front_q  <= len_q;
              out_fb_q <= len_q;
            end else begin
              out_fb_q <= front_q;
            end
          end
        end
        S_HDR_RD: begin
          // Read data is registered behind the address, so byte k is merged when hk_q is k + 1.
          hk_q <= hk_q + 1'b1;
          if (hk_q != '0) begin
            acc_q <= hdr_val;
          end
          if (hk_q == HCW'(HEADER_BYTES)) begin
            front_q <= hdr_val;
            if (ret_evict_q) begin
              state_q <= S_EVICT;
            end else begin
              out_fb_q    <= hdr_val;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end
        end
        S_POP_WAIT: begin
          out_st_q <= ST_OK;
          out_rb_q <= ram_rdata;
          out_bl_q <= front_q;
          out_ev_q <= '0;
          out_lb_q <= 1'b0;
          rem_q    <= rem_q - 1'b1;
          cur_q    <= wrap(WW'(cur_q) + WW'(1));
          if (rem_q == LEN_W'(1)) begin
            out_lb_q <= 1'b1;
            mode_q   <= MODE_IDLE;
            cur_q    <= '0;
            if (drop_empty) begin
              used_q      <= '0;
              start_q     <= '0;
              front_q     <= '0;
              out_sb_q    <= '0;
              out_fb_q    <= '0;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              used_q      <= drop_used;
              start_q     <= drop_start;
              out_sb_q    <= STORED_W'(drop_used);
              hk_q        <= '0;
              acc_q       <= '0;
              ret_evict_q <= 1'b0;
              state_q     <= S_HDR_RD;
            end
          end else begin
            out_sb_q    <= STORED_W'(used_q);
            out_fb_q    <= front_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_st_q;
  assign out_o.read_byte        = out_rb_q;
  assign out_o.block_length     = out_bl_q;
  assign out_o.last_byte        = out_lb_q;
  assign out_o.evicted_blocks   = out_ev_q;
  assign out_o.stored_bytes     = out_sb_q;
  assign out_o.front_block_size = out_fb_q;

endmodule
`default_nettype wire

@@ hdl/lpbr_ram.sv @@
`default_nettype none
module lpbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ hdl/lpbr_checker.sv @@
`default_nettype none
`include "length_prefixed_block_ring_macros.svh"
module lpbr_checker #(
  parameter int unsigned BUFFER_BYTES = lpbr_pkg::DEF_BUFFER_BYTES
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  lpbr_in_if.sink     in_i,
  lpbr_out_if.source  out_o
);
  import lpbr_pkg::*;

  `LPBR_ASSERT_NXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.stored_bytes) && $stable(out_o.status), "result beat changed while stalled")
  `LPBR_ASSERT_IMP(a_one_in_flight, in_i.ready, !out_o.valid, "command taken while a result is pending")
  `LPBR_ASSERT_NXT(a_busy_after_take, in_i.valid && in_i.ready, !in_i.ready, "second command taken before the first result")
  `LPBR_ASSERT_IMP(a_fill_bound, out_o.valid, 32'(out_o.stored_bytes) <= BUFFER_BYTES, "ring reports more bytes than it holds")
  `LPBR_ASSERT_IMP(a_reject_clean, out_o.valid && out_o.status == ST_BAD_LENGTH, out_o.block_length == '0 && !out_o.last_byte && out_o.evicted_blocks == '0, "rejected push reports side effects")

endmodule

bind length_prefixed_block_ring lpbr_checker #(
  .BUFFER_BYTES(BUFFER_BYTES)
) u_lpbr_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_i  (in_i),
  .out_o (out_o)
);
`default_nettype wire
